[sv/rled_pkg.sv]
// shared types and constants for the rgb led frame encoder
// no dependencies; imported by the encoder core

package rled_pkg;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_ENC   = 6'b010000,
        ST_DONE  = 6'b100000
    } rled_state_t;

    // register indexes on the apb port (word address)
    localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] REG_ONE_CODE    = 2'd1;
    localparam logic [1:0] REG_ZERO_CODE   = 2'd2;

    // commands
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // reset values of the configuration registers
    localparam logic [8:0] PIXEL_COUNT_RST = 9'd256;
    localparam logic [2:0] ONE_CODE_RST    = 3'd6;
    localparam logic [2:0] ZERO_CODE_RST   = 3'd4;

    // three components per pixel, three code bytes per component
    localparam logic [1:0] LAST_TRIPLE = 2'd2;
    localparam logic [2:0] LAST_COLOR_BIT = 3'd7;

endpackage

[sv/rled_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module rled_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/rgb_led_frame_spi_encoder_core.sv]
// rgb led frame encoder: pixel store, range fill and encoded byte stream
// depends on rled_pkg and rled_ram
// after reset a clearing pass zeroes the pixel store, in_ready low
// set transaction: the range is filled with one store write per cycle, then the result is
//   registered; an invalid range goes straight to the result without store writes
// send transaction: a leading zero byte goes straight to the result, a pixel byte takes
//   a store read, then eight steps of the shared bit encoder; one transaction at a time,
//   in_ready returns in the same cycle as the result is loaded
// reset: pixel_count 256, one_code 6, zero_code 4, stream at start of frame

module rgb_led_frame_spi_encoder_core
    import rled_pkg::*;
#(
    parameter int MAX_PIXELS      = 256,
    parameter int LEAD_ZERO_BYTES = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  first_led,
    input  logic [7:0]  last_led,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic        byte_valid,
    output logic [7:0]  stream_byte,
    output logic        frame_last
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LW = (LEAD_ZERO_BYTES > 0) ? $clog2(LEAD_ZERO_BYTES + 1) : 1;
    localparam logic [LW-1:0] LEAD_DONE = LW'(LEAD_ZERO_BYTES);
    localparam logic [LW-1:0] LEAD_LAST = LW'(LEAD_ZERO_BYTES - 1);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(MAX_PIXELS - 1);

    // configuration
    logic [8:0] pixel_count_reg;
    logic [2:0] one_code_reg;
    logic [2:0] zero_code_reg;
    logic       cfg_write;

    // sequencer and work registers
    rled_state_t state_reg, state_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic [7:0]    fill_idx_reg, fill_idx_next;
    logic [7:0]    fill_last_reg, fill_last_next;
    logic [23:0]   fill_color_reg, fill_color_next;
    logic [1:0]    comp_sel_reg, comp_sel_next;
    logic [1:0]    part_sel_reg, part_sel_next;
    logic [7:0]    color_sh_reg, color_sh_next;
    logic [23:0]   word_reg, word_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic          pend_status_reg, pend_status_next;
    logic          pend_bvalid_reg, pend_bvalid_next;
    logic          pend_last_reg, pend_last_next;
    logic          pend_zero_reg, pend_zero_next;

    // stream position, kept split as lead byte, pixel, component, code byte
    logic [LW-1:0] lead_reg, lead_next;
    logic [8:0]    pix_reg, pix_next;
    logic [1:0]    comp_reg, comp_next;
    logic [1:0]    part_reg, part_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       status_reg, status_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] stream_byte_reg, stream_byte_next;
    logic       frame_last_reg, frame_last_next;

    // store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    // position decode
    logic [8:0]    eff_count;
    logic          wrap;
    logic [LW-1:0] cur_lead;
    logic [8:0]    cur_pix;
    logic [1:0]    cur_comp;
    logic [1:0]    cur_part;
    logic          in_lead;
    logic          empty_frame;
    logic          is_last;
    logic          accept;
    logic          out_free;
    logic [7:0]    sel_byte;
    logic [7:0]    comp_byte;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_PIXEL_COUNT: prdata = 32'(pixel_count_reg);
            REG_ONE_CODE:    prdata = 32'(one_code_reg);
            REG_ZERO_CODE:   prdata = 32'(zero_code_reg);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= PIXEL_COUNT_RST;
            one_code_reg    <= ONE_CODE_RST;
            zero_code_reg   <= ZERO_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PIXEL_COUNT: pixel_count_reg <= pwdata[8:0];
                REG_ONE_CODE:    one_code_reg    <= pwdata[2:0];
                REG_ZERO_CODE:   zero_code_reg   <= pwdata[2:0];
                default:         ;
            endcase
        end
    end

    // pixel count saturates at the store depth
    assign eff_count = (int'(pixel_count_reg) > MAX_PIXELS) ? 9'(MAX_PIXELS) : pixel_count_reg;

    // a position past the frame end (count shrank) restarts the frame
    assign wrap     = (lead_reg == LEAD_DONE) && (pix_reg >= eff_count);
    assign cur_lead = wrap ? '0 : lead_reg;
    assign cur_pix  = wrap ? 9'd0 : pix_reg;
    assign cur_comp = wrap ? 2'd0 : comp_reg;
    assign cur_part = wrap ? 2'd0 : part_reg;
    assign in_lead  = (cur_lead != LEAD_DONE);
    assign empty_frame = (LEAD_ZERO_BYTES == 0) && (eff_count == 9'd0);

    always_comb
    begin
        if (in_lead)
        begin
            is_last = (eff_count == 9'd0) && (cur_lead == LEAD_LAST);
        end
        else
        begin
            is_last = (cur_pix == eff_count - 9'd1) && (cur_comp == LAST_TRIPLE)
                      && (cur_part == LAST_TRIPLE);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign status      = status_reg;
    assign byte_valid  = byte_valid_reg;
    assign stream_byte = stream_byte_reg;
    assign frame_last  = frame_last_reg;

    // store write port: clearing pass or range fill
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : AW'(fill_idx_reg);
    assign ram_wdata = (state_reg == ST_CLEAR) ? 24'd0 : fill_color_reg;
    assign ram_raddr = AW'(cur_pix);

    rled_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // component of the stored green, red, blue word
    always_comb
    begin
        case (comp_sel_reg)
            2'd0:    comp_byte = ram_rdata[23:16];
            2'd1:    comp_byte = ram_rdata[15:8];
            default: comp_byte = ram_rdata[7:0];
        endcase
    end

    // code byte, high byte first
    always_comb
    begin
        case (part_sel_reg)
            2'd0:    sel_byte = word_reg[23:16];
            2'd1:    sel_byte = word_reg[15:8];
            default: sel_byte = word_reg[7:0];
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        fill_idx_next    = fill_idx_reg;
        fill_last_next   = fill_last_reg;
        fill_color_next  = fill_color_reg;
        comp_sel_next    = comp_sel_reg;
        part_sel_next    = part_sel_reg;
        color_sh_next    = color_sh_reg;
        word_next        = word_reg;
        bit_cnt_next     = bit_cnt_reg;
        pend_status_next = pend_status_reg;
        pend_bvalid_next = pend_bvalid_reg;
        pend_last_next   = pend_last_reg;
        pend_zero_next   = pend_zero_reg;
        lead_next        = lead_reg;
        pix_next         = pix_reg;
        comp_next        = comp_reg;
        part_next        = part_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        byte_valid_next  = byte_valid_reg;
        stream_byte_next = stream_byte_reg;
        frame_last_next  = frame_last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_status_next = 1'b0;
                    pend_bvalid_next = 1'b0;
                    pend_last_next   = 1'b0;
                    pend_zero_next   = 1'b1;
                    if (command == CMD_SET)
                    begin
                        lead_next = '0;
                        pix_next  = 9'd0;
                        comp_next = 2'd0;
                        part_next = 2'd0;
                        fill_idx_next   = first_led;
                        fill_last_next  = last_led;
                        fill_color_next = {green, red, blue};
                        if ((first_led > last_led) || ({1'b0, last_led} >= eff_count))
                        begin
                            pend_status_next = 1'b1;
                            state_next       = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FILL;
                        end
                    end
                    else if (empty_frame)
                    begin
                        lead_next  = '0;
                        pix_next   = 9'd0;
                        comp_next  = 2'd0;
                        part_next  = 2'd0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pend_bvalid_next = 1'b1;
                        pend_last_next   = is_last;
                        comp_sel_next    = cur_comp;
                        part_sel_next    = cur_part;
                        if (is_last)
                        begin
                            lead_next = '0;
                            pix_next  = 9'd0;
                            comp_next = 2'd0;
                            part_next = 2'd0;
                        end
                        else if (in_lead)
                        begin
                            lead_next = cur_lead + LW'(1);
                            pix_next  = cur_pix;
                            comp_next = cur_comp;
                            part_next = cur_part;
                        end
                        else
                        begin
                            lead_next = cur_lead;
                            if (cur_part != LAST_TRIPLE)
                            begin
                                pix_next  = cur_pix;
                                comp_next = cur_comp;
                                part_next = cur_part + 2'd1;
                            end
                            else if (cur_comp != LAST_TRIPLE)
                            begin
                                pix_next  = cur_pix;
                                comp_next = cur_comp + 2'd1;
                                part_next = 2'd0;
                            end
                            else
                            begin
                                pix_next  = cur_pix + 9'd1;
                                comp_next = 2'd0;
                                part_next = 2'd0;
                            end
                        end
                        if (in_lead)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pend_zero_next = 1'b0;
                            state_next     = ST_LOAD;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                fill_idx_next = fill_idx_reg + 8'd1;
                if (fill_idx_reg == fill_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                color_sh_next = comp_byte;
                word_next     = 24'd0;
                bit_cnt_next  = 3'd0;
                state_next    = ST_ENC;
            end
            ST_ENC:
            begin
                // one color bit per cycle, msb first, into the code word
                word_next     = {word_reg[20:0], color_sh_reg[7] ? one_code_reg : zero_code_reg};
                color_sh_next = {color_sh_reg[6:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == LAST_COLOR_BIT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = pend_status_reg;
                    byte_valid_next  = pend_bvalid_reg;
                    stream_byte_next = pend_zero_reg ? 8'd0 : sel_byte;
                    frame_last_next  = pend_last_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            lead_reg      <= '0;
            pix_reg       <= 9'd0;
            comp_reg      <= 2'd0;
            part_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            lead_reg      <= lead_next;
            pix_reg       <= pix_next;
            comp_reg      <= comp_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_idx_reg    <= fill_idx_next;
        fill_last_reg   <= fill_last_next;
        fill_color_reg  <= fill_color_next;
        comp_sel_reg    <= comp_sel_next;
        part_sel_reg    <= part_sel_next;
        color_sh_reg    <= color_sh_next;
        word_reg        <= word_next;
        bit_cnt_reg     <= bit_cnt_next;
        pend_status_reg <= pend_status_next;
        pend_bvalid_reg <= pend_bvalid_next;
        pend_last_reg   <= pend_last_next;
        pend_zero_reg   <= pend_zero_next;
        status_reg      <= status_next;
        byte_valid_reg  <= byte_valid_next;
        stream_byte_reg <= stream_byte_next;
        frame_last_reg  <= frame_last_next;
    end

endmodule

[bench/tb_top.sv]
// testbench for rgb_led_frame_spi_encoder_core: range fills, encoded stream bytes, apb setup
// depends on rled_pkg and the encoder rtl; self-checking, no external files

module tb_top
    import rled_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAD_BYTES    = 1;
    localparam int STORE_DEPTH   = 256;
    localparam int BYTES_PER_LED = 9;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic       status;
        logic       byte_valid;
        logic [7:0] stream_byte;
        logic       frame_last;
    } frame_result_t;

    class led_frame_scoreboard;
        logic [23:0]   pixel_colors [STORE_DEPTH];
        int unsigned   byte_index;
        logic [8:0]    pixel_count;
        logic [2:0]    one_code;
        logic [2:0]    zero_code;
        frame_result_t expected_replies [$];
        int unsigned   error_count;
        int unsigned   fill_count;
        int unsigned   rejected_count;
        int unsigned   byte_count;
        int unsigned   frame_count;

        function new();
            foreach (pixel_colors[p])
                pixel_colors[p] = '0;
            byte_index  = 0;
            pixel_count = PIXEL_COUNT_RST;
            one_code    = ONE_CODE_RST;
            zero_code   = ZERO_CODE_RST;
        endfunction

        function void write_register(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_PIXEL_COUNT: pixel_count = value[8:0];
                REG_ONE_CODE:    one_code = value[2:0];
                REG_ZERO_CODE:   zero_code = value[2:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [1:0] index);
            case (index)
                REG_PIXEL_COUNT: return 32'(pixel_count);
                REG_ONE_CODE:    return 32'(one_code);
                REG_ZERO_CODE:   return 32'(zero_code);
                default:         return 32'd0;
            endcase
        endfunction

        function int unsigned live_pixels();
            return (pixel_count > STORE_DEPTH) ? STORE_DEPTH : int'(pixel_count);
        endfunction

        // eight three-bit codes, msb of the component first
        function logic [23:0] line_code_word(logic [7:0] component);
            logic [23:0] word;
            int          b;
            word = '0;
            for (b = 7; b >= 0; b--)
                word = {word[20:0], component[b] ? one_code : zero_code};
            return word;
        endfunction

        function void note_transaction(logic cmd, logic [7:0] first, logic [7:0] last,
                                       logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            frame_result_t reply;
            int unsigned   live;
            int unsigned   frame_len;
            int unsigned   pos;
            int unsigned   k;
            int unsigned   byte_in_pixel;
            logic [7:0]    component;
            int            p;
            reply = '0;
            live  = live_pixels();
            if (cmd == CMD_SET) begin
                byte_index = 0;
                fill_count++;
                if (first > last || last >= live) begin
                    reply.status = 1'b1;
                    rejected_count++;
                end else begin
                    for (p = first; p <= last; p++)
                        pixel_colors[p] = {green, red, blue};
                end
            end else begin
                frame_len = LEAD_BYTES + live * BYTES_PER_LED;
                pos = (byte_index >= frame_len) ? 0 : byte_index;
                reply.byte_valid = 1'b1;
                if (pos >= LEAD_BYTES) begin
                    k             = pos - LEAD_BYTES;
                    byte_in_pixel = k % BYTES_PER_LED;
                    component     = 8'(pixel_colors[k / BYTES_PER_LED]
                                       >> (16 - 8 * (byte_in_pixel / 3)));
                    reply.stream_byte = 8'(line_code_word(component)
                                           >> (16 - 8 * (byte_in_pixel % 3)));
                end
                if (pos == frame_len - 1) begin
                    reply.frame_last = 1'b1;
                    byte_index = 0;
                    frame_count++;
                end else begin
                    byte_index = pos + 1;
                end
                byte_count++;
            end
            expected_replies.push_back(reply);
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            error_count++;
        endtask

        task check_result(logic st, logic bv, logic [7:0] data, logic fl);
            frame_result_t want;
            if (expected_replies.size() == 0) begin
                report($sformatf("result with nothing pending, byte %02h", data));
                return;
            end
            want = expected_replies.pop_front();
            if (st !== want.status)
                report($sformatf("status %b, expected %b", st, want.status));
            if (bv !== want.byte_valid)
                report($sformatf("byte_valid %b, expected %b", bv, want.byte_valid));
            if (data !== want.stream_byte)
                report($sformatf("stream_byte %02h, expected %02h", data, want.stream_byte));
            if (fl !== want.frame_last)
                report($sformatf("frame_last %b, expected %b", fl, want.frame_last));
        endtask
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        command     = CMD_SEND;
    logic [7:0]  first_led   = '0;
    logic [7:0]  last_led    = '0;
    logic [7:0]  red         = '0;
    logic [7:0]  green       = '0;
    logic [7:0]  blue        = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        status;
    logic        byte_valid;
    logic [7:0]  stream_byte;
    logic        frame_last;

    led_frame_scoreboard sb = new();
    bit          quiet = 1'b0;
    int unsigned items_driven = 0;
    int unsigned settings_count = 0;
    int unsigned cycle_count = 0;

    rgb_led_frame_spi_encoder_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .first_led   (first_led),
        .last_led    (last_led),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .byte_valid  (byte_valid),
        .stream_byte (stream_byte),
        .frame_last  (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, sb.expected_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, a few long ones, none while quiet
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check accepted transactions, then pick next ready value
    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(status, byte_valid, stream_byte, frame_last);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = idle_cycles();
            end
        end
    end

    task automatic apb_write(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(index, value);
        @(posedge clk);
        // address still points at the register just written
        if (prdata !== sb.register_value(index))
            sb.report($sformatf("register %0d reads %08h, expected %08h",
                                index, prdata, sb.register_value(index)));
    endtask

    task automatic configure(int unsigned leds, int unsigned one_pat, int unsigned zero_pat);
        apb_write(REG_PIXEL_COUNT, leds);
        apb_write(REG_ONE_CODE, one_pat);
        apb_write(REG_ZERO_CODE, zero_pat);
        settings_count++;
    endtask

    task automatic drive_item(logic cmd, logic [7:0] first, logic [7:0] last,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        first_led <= first;
        last_led  <= last;
        red       <= r;
        green     <= g;
        blue      <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_transaction(cmd, first, last, r, g, b);
        items_driven++;
    endtask

    task automatic set_range(logic [7:0] first, logic [7:0] last,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        drive_item(CMD_SET, first, last, r, g, b);
    endtask

    // range fields ride along on sends and must be ignored
    task automatic send_byte();
        drive_item(CMD_SEND, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
    endtask

    task automatic valid_fill();
        int unsigned live;
        int unsigned first;
        int unsigned last;
        int unsigned span;
        live = sb.live_pixels();
        if (live == 0)
            return;
        first = $urandom_range(0, live - 1);
        if ($urandom_range(0, 3) != 0)
        begin
            span = $urandom_range(0, 7);
            last = (first + span < live) ? first + span : live - 1;
        end
        else
            last = $urandom_range(first, live - 1);
        if (last < first)
            last = first;
        set_range(8'(first), 8'(last), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic noise_item();
        int unsigned live;
        logic [7:0]  first;
        logic [7:0]  last;
        live = sb.live_pixels();
        if ($urandom_range(0, 1) == 0)
        begin
            first = 8'($urandom);
            last  = 8'($urandom);
        end
        else
        begin
            first = 8'($urandom_range(0, live + 1));
            last  = 8'($urandom_range(0, live + 1));
        end
        drive_item(1'($urandom), first, last, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // idle the input and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int unsigned pick;
        int unsigned leds;
        int unsigned frame_len;
        int unsigned n;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            leds = $urandom_range(1, 8);
        else if (pick == 6)
            leds = 0;
        else if (pick == 7)
            leds = $urandom_range(257, 511);
        else if (pick == 8)
            leds = 256;
        else
            leds = $urandom_range(9, 40);
        settle();
        configure(leds, $urandom_range(0, 7), $urandom_range(0, 7));
        quiet = ($urandom_range(0, 3) == 0);
        frame_len = LEAD_BYTES + sb.live_pixels() * BYTES_PER_LED;
        if ($urandom_range(0, 3) != 0)
        begin
            // fills, then a whole frame plus up to one more of sends; a count above 90 is redrawn from 40 to 90
            repeat ($urandom_range(0, 4)) valid_fill();
            n = frame_len + $urandom_range(0, frame_len);
            if (n > 90)
                n = $urandom_range(40, 90);
            repeat (n) send_byte();
            repeat ($urandom_range(0, 4)) noise_item();
        end
        else
        begin
            repeat ($urandom_range(10, 30)) noise_item();
        end
    endtask

    initial
    begin
        int unsigned random_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // store clearing pass holds in_ready low
        do @(posedge clk); while (!(rst_n && in_ready));

        // reset settings: full range fill, single pixel at the top, reversed range
        set_range(8'd0, 8'd255, 8'h00, 8'hff, 8'h5a);
        set_range(8'd255, 8'd255, 8'hff, 8'h00, 8'hff);
        set_range(8'd5, 8'd4, 8'h12, 8'h34, 8'h56);
        repeat (3) send_byte();

        // no pixels: position now past the end, every set rejected
        settle();
        configure(0, 32'(ONE_CODE_RST), 32'(ZERO_CODE_RST));
        send_byte();
        set_range(8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
        send_byte();

        // one pixel, extreme codes, a whole frame and the wrap
        settle();
        configure(1, 7, 0);
        set_range(8'd0, 8'd1, 8'h11, 8'h22, 8'h33);
        set_range(8'd0, 8'd0, 8'h00, 8'hff, 8'ha5);
        repeat (11) send_byte();

        // count above the store size saturates
        settle();
        configure(511, 0, 7);
        set_range(8'd0, 8'd255, 8'h3c, 8'hc3, 8'h00);
        repeat (2) send_byte();

        random_start = items_driven;
        while (items_driven - random_start < RANDOM_ITEMS)
            random_phase();

        settle();
        $display("%0d transactions: %0d range fills (%0d rejected), %0d stream bytes",
                 items_driven, sb.fill_count, sb.rejected_count, sb.byte_count);
        $display("%0d frame ends seen across %0d register settings, %0d mismatches",
                 sb.frame_count, settings_count, sb.error_count);
        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
